### src/lats_pkg.sv
// Shared types, codes and constants for the literal activity score table.
package lats_pkg;

  localparam int unsigned VARS_DEF         = 1024;
  localparam int unsigned HALVE_PERIOD_DEF = 256;

  localparam int unsigned LIT_W   = 11;
  localparam int unsigned GAP_W   = 7;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned IN_W    = 24;

  // Reciprocal of 100 for 32-bit operands: q = (s * RECIP_100) >> RECIP_SH
  localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
  localparam int unsigned RECIP_SH  = 37;
  // Reciprocal of 100 for operands below 10000: q = (x * RECIP_SMALL) >> 19
  localparam logic [12:0] RECIP_SMALL = 13'd5243;
  localparam int unsigned RECIP_SMALL_SH = 19;

  localparam logic [1:0] OP_UPDATE    = 2'd0;
  localparam logic [1:0] OP_DECAY     = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;
  localparam logic [1:0] OP_QUERY_ALT = 2'd3;

  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_DECAY = 2'd1;
  localparam logic [1:0] MODE_HALVE = 2'd2;
  localparam logic [1:0] MODE_AVG   = 2'd3;

  // Per-entry operation carried down the datapath pipe
  typedef enum logic [2:0] {
    K_KEEP,
    K_INC,
    K_AVG,
    K_DECAY,
    K_SCALE,
    K_HALVE
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_SWEEP,
    ST_DRAIN,
    ST_ISSUE,
    ST_WAIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;        // take the accepted request
    logic clr_wr;      // write zero at the pointer, advance
    logic ptr_low;     // load the pointer with the sweep start
    logic sweep_issue; // read the pointer entry into the pipe, advance
    logic lit_issue;   // read the literal's entry into the pipe
  } cmd_t;

  typedef struct packed {
    logic ptr_last;
    logic sweep_go;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

### src/lats_ctrl.sv
// Sequencer for clearing, table sweeps and literal read-modify-writes.
module lats_ctrl
  import lats_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (sts_i.ptr_last) state_d = ST_IDLE;
      ST_IDLE:   if (s_axis_tvalid_i) state_d = ST_DECIDE;
      ST_DECIDE: state_d = sts_i.sweep_go ? ST_SWEEP : ST_ISSUE;
      ST_SWEEP:  if (sts_i.ptr_last) state_d = ST_DRAIN;
      ST_DRAIN:  if (!sts_i.pipe_busy) state_d = ST_ISSUE;
      ST_ISSUE:  if (sts_i.out_free) state_d = ST_WAIT;
      ST_WAIT:   if (!sts_i.pipe_busy) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_CLEAR:  cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.load = s_axis_tvalid_i;
      end
      ST_DECIDE: cmd_o.ptr_low = sts_i.sweep_go;
      ST_SWEEP:  cmd_o.sweep_issue = 1'b1;
      ST_ISSUE:  cmd_o.lit_issue = sts_i.out_free;
      default: ;
    endcase
  end

  a_lit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.lit_issue |-> (sts_i.out_free && !sts_i.pipe_busy))
    else $error("literal issued into a busy pipe or full output");

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.clr_wr, cmd_o.ptr_low, cmd_o.sweep_issue, cmd_o.lit_issue}))
    else $error("conflicting datapath commands");

  a_accept_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == ST_DECIDE))
    else $error("accepted request not followed by decision");

endmodule

### src/lats_dp.sv
// Score memory, cube bookkeeping, arithmetic pipe and output register.
module lats_dp
  import lats_pkg::*;
#(
  parameter int unsigned VARS         = VARS_DEF,
  parameter int unsigned HALVE_PERIOD = HALVE_PERIOD_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic [IN_W-1:0]    s_axis_tdata_i,
  input  logic               s_axis_tlast_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [SCORE_W-1:0] m_axis_tdata_o,
  input  cmd_t               cmd_i,
  output sts_t               sts_o
);

  localparam int unsigned AW    = $clog2(VARS);
  localparam int unsigned LW    = $clog2(VARS + 1);
  localparam int unsigned CMP_W = (LW > LIT_W) ? LW : LIT_W;
  localparam int unsigned Q_W   = SCORE_W - (RECIP_SH - 32);

  logic [SCORE_W-1:0] mem [VARS];

  // Configuration and cube state
  logic [1:0]       mode_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [LW-1:0]    lowest_q, lowest_d;
  logic             within_q, within_d;

  // Current request
  logic [1:0]       opc_q;
  logic [LIT_W-1:0] idx_q;
  logic             ok_q;
  logic [GAP_W-1:0] gap_q;
  logic             sweep_pend_q, halve_q;
  logic [LW-1:0]    sweep_lo_q;

  // Unpack and classify the incoming request
  logic [1:0]       in_opc;
  logic [LIT_W-1:0] in_lit, in_idx;
  logic [GAP_W-1:0] in_gap;
  logic             in_cube, in_first, in_halve, in_ok;
  logic [CNT_W-1:0] cnt_inc;

  assign in_opc  = s_axis_tdata_i[1:0];
  assign in_lit  = s_axis_tdata_i[LIT_W+1:2];
  assign in_gap  = s_axis_tdata_i[LIT_W+GAP_W+1:LIT_W+2];
  assign in_idx  = in_lit[LIT_W-1] ? (~in_lit + LIT_W'(1)) : in_lit;
  assign in_ok   = CMP_W'(in_idx) < CMP_W'(VARS);
  assign in_cube = (in_opc == OP_UPDATE) || (in_opc == OP_DECAY);
  assign in_first = in_cube && !within_q;
  assign cnt_inc = count_q + CNT_W'(1);
  assign in_halve = in_first && (in_opc == OP_UPDATE) && (mode_q == MODE_HALVE)
                    && ({1'b0, cnt_inc} == (CNT_W+1)'(HALVE_PERIOD));

  always_comb begin
    count_d  = count_q;
    lowest_d = lowest_q;
    within_d = within_q;
    if (in_first) begin
      count_d = in_halve ? '0 : cnt_inc;
      if (CMP_W'(in_idx) < CMP_W'(lowest_q)) lowest_d = LW'(in_idx);
    end
    if (in_cube) within_d = !s_axis_tlast_i;
  end

  // Hold configuration and cube state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_DECAY;
      count_q      <= CNT_W'(1);
      lowest_q     <= LW'(VARS);
      within_q     <= 1'b0;
      sweep_pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (cmd_i.load) begin
        count_q      <= count_d;
        lowest_q     <= lowest_d;
        within_q     <= within_d;
        sweep_pend_q <= in_halve ||
                        (in_first && (in_opc == OP_UPDATE) && (mode_q == MODE_DECAY));
      end
    end
  end

  // Latch the request payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      opc_q      <= in_opc;
      idx_q      <= in_idx;
      ok_q       <= in_ok;
      gap_q      <= in_gap;
      halve_q    <= in_halve;
      sweep_lo_q <= lowest_q;
    end
  end

  // Sweep and clear pointer
  logic [AW-1:0] ptr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_low) begin
      ptr_q <= AW'(sweep_lo_q);
    end else if (cmd_i.clr_wr || cmd_i.sweep_issue) begin
      ptr_q <= ptr_q + AW'(1);
    end
  end

  // Issue: pick address and operation
  logic          issue;
  logic [AW-1:0] rd_addr;
  kind_e         kind_in;
  logic          wr_in, out_in;

  assign issue = cmd_i.sweep_issue || cmd_i.lit_issue;

  always_comb begin
    rd_addr = ptr_q;
    kind_in = halve_q ? K_HALVE : K_SCALE;
    wr_in   = 1'b1;
    out_in  = 1'b0;
    if (cmd_i.lit_issue) begin
      rd_addr = AW'(idx_q);
      out_in  = 1'b1;
      wr_in   = ok_q && ((opc_q == OP_UPDATE) || (opc_q == OP_DECAY));
      kind_in = K_KEEP;
      if (opc_q == OP_DECAY) begin
        kind_in = K_DECAY;
      end else if (opc_q == OP_UPDATE) begin
        case (mode_q)
          MODE_DECAY, MODE_HALVE: kind_in = K_INC;
          MODE_AVG:               kind_in = K_AVG;
          default:                kind_in = K_KEEP;
        endcase
      end
    end
  end

  // Pipe control
  logic          v1_q, v2_q, v3_q;
  kind_e         k1_q, k2_q, k3_q;
  logic [AW-1:0] a1_q, a2_q, a3_q;
  logic          w1_q, w2_q, w3_q;
  logic          o1_q, o2_q, o3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Decay factor numerator
  logic [GAP_W-1:0] num;
  assign num = (gap_q > GAP_W'(101)) ? '0 : (GAP_W'(101) - gap_q);

  // Stage payload
  logic [SCORE_W-1:0] rdata_q, s2_q, s3_q;
  logic [63:0]        prod1;
  logic [Q_W-1:0]     q2_q, q3_q;
  logic [6:0]         r2, r3_q;
  logic [Q_W+GAP_W-1:0] qn3_q;
  logic [13:0]        rn3_q;

  assign prod1 = 64'(rdata_q) * 64'(RECIP_100);
  assign r2    = 7'(s2_q - SCORE_W'(q2_q * 7'd100));

  always_ff @(posedge clk_i) begin
    k1_q  <= kind_in;
    a1_q  <= rd_addr;
    w1_q  <= wr_in;
    o1_q  <= out_in;
    k2_q  <= k1_q;
    a2_q  <= a1_q;
    w2_q  <= w1_q;
    o2_q  <= o1_q;
    s2_q  <= rdata_q;
    q2_q  <= prod1[RECIP_SH+Q_W-1:RECIP_SH];
    k3_q  <= k2_q;
    a3_q  <= a2_q;
    w3_q  <= w2_q;
    o3_q  <= o2_q;
    s3_q  <= s2_q;
    q3_q  <= q2_q;
    r3_q  <= r2;
    qn3_q <= (Q_W+GAP_W)'(q2_q) * (Q_W+GAP_W)'(num);
    rn3_q <= 14'(r2) * 14'(num);
  end

  // Final arithmetic
  logic [SCORE_W:0]       inc_sum, avg_sum;
  logic [26:0]            rn_prod;
  logic [Q_W+GAP_W-1:0]   dec_sum;
  logic [SCORE_W-1:0]     res;

  assign inc_sum = {1'b0, s3_q} + (SCORE_W+1)'(32'h0001_0000);
  assign avg_sum = {1'b0, s3_q} + {1'b0, count_q, 16'h0000};
  assign rn_prod = 27'(rn3_q) * 27'(RECIP_SMALL);
  assign dec_sum = qn3_q + (Q_W+GAP_W)'(rn_prod[26:RECIP_SMALL_SH]);

  always_comb begin
    case (k3_q)
      K_INC:   res = inc_sum[SCORE_W] ? '1 : inc_sum[SCORE_W-1:0];
      K_AVG:   res = avg_sum[SCORE_W:1];
      K_DECAY: res = (|dec_sum[Q_W+GAP_W-1:SCORE_W]) ? '1 : dec_sum[SCORE_W-1:0];
      K_SCALE: res = s3_q - SCORE_W'(q3_q) - SCORE_W'(r3_q != 7'd0);
      K_HALVE: res = s3_q >> 1;
      default: res = s3_q;
    endcase
  end

  // Score memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem[ptr_q] <= '0;
    end else if (v3_q && w3_q) begin
      mem[a3_q] <= res;
    end
    if (issue) rdata_q <= mem[rd_addr];
  end

  // Output register
  logic               m_valid_q;
  logic [SCORE_W-1:0] m_data_q;
  logic               ok_out;

  assign ok_out = ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (v3_q && o3_q) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && o3_q) m_data_q <= ok_out ? res : '0;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  assign sts_o.ptr_last  = (ptr_q == AW'(VARS - 1));
  assign sts_o.sweep_go  = sweep_pend_q && (CMP_W'(sweep_lo_q) < CMP_W'(VARS));
  assign sts_o.pipe_busy = v1_q || v2_q || v3_q;
  assign sts_o.out_free  = !m_valid_q || m_axis_tready_i;

endmodule

### src/literal_activity_score_table_core.sv
// Top level of the literal activity score table.
//
// Requests enter on the s_axis channel, one cube literal or query each;
// every request yields one Q16.16 score on the m_axis channel, in order.
// The mode register is written through cfg_we_i/cfg_wdata_i; the user
// must write it only while idle, as the block does not enforce this.
// A plain request passes a decision state, an issue state that waits for
// a free output register, a registered memory read, a reciprocal multiply
// stage and a factor stage whose result is written back and loaded into
// the output register. The input reopens only once the pipe has drained.
// The first update literal of a cube in mode 1 (or in mode 2 when the
// halving period is reached) first sweeps the table, one entry per cycle,
// from the lowest first-literal index of earlier cubes to VARS-1, then
// drains the pipe. After reset it clears the score memory, one entry per
// cycle from 0 to VARS-1; s_axis_tready_o stays low during that pass.
// The result waits in an output register; a new request is taken while it
// waits, but its own result is not issued until that register frees up.
module literal_activity_score_table_core
  import lats_pkg::*;
#(
  parameter int unsigned VARS         = VARS_DEF,
  parameter int unsigned HALVE_PERIOD = HALVE_PERIOD_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,    // mode
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [IN_W-1:0]    s_axis_tdata_i, // opcode[1:0], literal[12:2], gap[19:13]
  input  logic               s_axis_tlast_i,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [SCORE_W-1:0] m_axis_tdata_o  // score[31:0]
);

  cmd_t cmd;
  sts_t sts;

  lats_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  lats_dp #(
    .VARS         (VARS),
    .HALVE_PERIOD (HALVE_PERIOD)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

### dv/literal_activity_score_table_core_test.sv
// Testbench for the literal activity score table: random cubes and queries against a local model.
module literal_activity_score_table_core_test
  import lats_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 10000000;

  // Tracks the score table and cube state, and holds the scores still to come
  class score_board;
    logic [31:0] score_tbl [VARS_DEF];
    logic [15:0] conflicts;
    int unsigned low_idx;
    bit          in_cube;
    logic [1:0]  mode;
    logic [31:0] pending_scores [$];
    int unsigned errors;

    function new();
      foreach (score_tbl[i]) score_tbl[i] = '0;
      conflicts = 16'd1;
      low_idx   = VARS_DEF;
      in_cube   = 1'b0;
      mode      = MODE_DECAY;
      errors    = 0;
    endfunction

    function void report(string what);
      errors++;
      $display("ERROR @%0t: %s", $realtime, what);
    endfunction

    // Advance the table by one accepted request and queue its score
    function void note_request(logic [1:0] op, logic [LIT_W-1:0] lit, bit last,
                               logic [GAP_W-1:0] gap);
      int unsigned idx;
      bit          ok;
      logic [63:0] s;
      int unsigned num;
      idx = lit[LIT_W-1] ? ((2048 - int'(lit)) & 32'h7FF) : int'(lit);
      ok  = idx < VARS_DEF;
      if (op == OP_UPDATE || op == OP_DECAY) begin
        if (!in_cube) begin
          conflicts++;
          if (op == OP_UPDATE) begin
            if (mode == MODE_DECAY) begin
              for (int i = low_idx; i < VARS_DEF; i++)
                score_tbl[i] = (64'(score_tbl[i]) * 99) / 100;
            end else if (mode == MODE_HALVE && conflicts == HALVE_PERIOD_DEF) begin
              for (int i = low_idx; i < VARS_DEF; i++)
                score_tbl[i] = score_tbl[i] >> 1;
              conflicts = '0;
            end
          end
          if (idx < low_idx) low_idx = idx;
        end
        in_cube = !last;
        if (ok) begin
          s = 64'(score_tbl[idx]);
          if (op == OP_UPDATE) begin
            if (mode == MODE_DECAY || mode == MODE_HALVE) s = s + 64'd65536;
            else if (mode == MODE_AVG) s = (s + (64'(conflicts) << 16)) >> 1;
          end else begin
            num = (gap > 101) ? 0 : 101 - gap;
            s = (s * num) / 100;
          end
          score_tbl[idx] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        end
      end
      pending_scores.push_back(ok ? score_tbl[idx] : 32'd0);
    endfunction

    // Compare one returned score with the oldest one queued
    function void check_score(logic [31:0] got);
      logic [31:0] want;
      if (pending_scores.size() == 0) begin
        report($sformatf("unexpected score %h", got));
      end else begin
        want = pending_scores.pop_front();
        if (got !== want) report($sformatf("score %h, expected %h", got, want));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_wdata = MODE_DECAY;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [SCORE_W-1:0] m_tdata;

  score_board sb = new();
  int unsigned cycles = 0;
  bit steady = 1'b0;
  int unsigned stall_left = 0;
  int unsigned sent = 0;

  always #2 clk_i = ~clk_i;

  literal_activity_score_table_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned pick_wait();
    if (steady) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  // Check results, then stall the result side at random
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) sb.check_score(m_tdata);
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_wait();
    end
  end

  // Drive one request and hold it until accepted
  task automatic send_request(logic [1:0] op, logic [LIT_W-1:0] lit, bit last,
                              logic [GAP_W-1:0] gap);
    int unsigned idle;
    idle = pick_wait();
    if (idle > 0) begin
      s_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, gap, lit, op};
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    sb.note_request(op, lit, last, gap);
    sent++;
  endtask

  // Drain outstanding scores, then write the mode
  task automatic set_mode(logic [1:0] m);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_scores.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk_i);
    sb.mode = m;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [LIT_W-1:0] pick_lit();
    int v;
    if ($urandom_range(0, 9) < 6) begin
      v = $urandom_range(0, 15);
      return $urandom_range(0, 1) ? LIT_W'(-v) : LIT_W'(v);
    end
    return LIT_W'($urandom);
  endfunction

  function automatic logic [GAP_W-1:0] pick_gap();
    if ($urandom_range(0, 9) < 7) return GAP_W'($urandom_range(90, 101));
    return GAP_W'($urandom_range(0, 127));
  endfunction

  // Mostly well-formed cubes with random content, plus queries and stray literals
  task automatic run_phase(logic [1:0] m, int unsigned n, bit short_cubes);
    int unsigned stop;
    int unsigned len;
    int unsigned r;
    logic [1:0] kind;
    logic [1:0] op;
    set_mode(m);
    steady = ($urandom_range(0, 3) == 0);
    stop = sent + n;
    while (sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_request($urandom_range(0, 1) ? OP_QUERY_ALT : OP_QUERY, pick_lit(),
                     1'($urandom), GAP_W'($urandom));
      end else if (r < 20) begin
        send_request($urandom_range(0, 1) ? OP_DECAY : OP_UPDATE, pick_lit(),
                     1'($urandom), pick_gap());
      end else begin
        kind = ($urandom_range(0, 9) < 7) ? OP_UPDATE : OP_DECAY;
        len = short_cubes ? 1 : $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          op = ($urandom_range(0, 9) == 0) ? (kind ^ 2'd1) : kind;
          send_request(op, pick_lit(), i == len - 1, pick_gap());
        end
      end
      if ($urandom_range(0, 49) == 0) steady = !steady;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Field extremes, every operation, mixed cube and out-of-range index
    send_request(OP_UPDATE, 11'd5, 1'b1, 7'd1);
    send_request(OP_UPDATE, -11'sd5, 1'b1, 7'd1);
    send_request(OP_UPDATE, 11'd1023, 1'b1, 7'd1);
    send_request(OP_UPDATE, -11'sd1023, 1'b1, 7'd127);
    send_request(OP_UPDATE, 11'h400, 1'b1, 7'd0);
    send_request(OP_UPDATE, 11'd0, 1'b1, 7'd0);
    send_request(OP_UPDATE, 11'd5, 1'b0, 7'd1);
    send_request(OP_DECAY, 11'd1023, 1'b0, 7'd0);
    send_request(OP_UPDATE, 11'd7, 1'b1, 7'd1);
    send_request(OP_DECAY, 11'd5, 1'b1, 7'd1);
    send_request(OP_DECAY, 11'd1023, 1'b1, 7'd101);
    send_request(OP_DECAY, 11'd0, 1'b1, 7'd127);
    send_request(OP_DECAY, 11'h400, 1'b1, 7'd50);
    send_request(OP_DECAY, -11'sd5, 1'b1, 7'd0);
    send_request(OP_QUERY, 11'd5, 1'b0, 7'd127);
    send_request(OP_QUERY_ALT, -11'sd5, 1'b1, 7'd0);
    send_request(OP_QUERY, 11'h400, 1'b1, 7'd0);
    send_request(OP_QUERY_ALT, 11'd1023, 1'b0, 7'd127);
    // Halving needs many conflicts, so run it while the counter is still low
    run_phase(MODE_HALVE, 300, 1'b1);
    run_phase(MODE_AVG, 250, 1'b0);
    run_phase(MODE_OFF, 200, 1'b0);
    run_phase(MODE_DECAY, 250, 1'b0);
    run_phase(MODE_HALVE, 250, 1'b0);
    run_phase(MODE_AVG, 250, 1'b0);
    s_tvalid <= 1'b0;
    while (sb.pending_scores.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
